// ===== design/mfec_pkg.sv =====
// ----------------------------------------------------------------------------
// mfec_pkg
// Shared types, codes and helpers for the most-frequent-evict store.
// ----------------------------------------------------------------------------
package mfec_pkg;

    localparam int CNT_BITS  = 32;
    localparam int IDX_MAX_W = 8;
    localparam int CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Update commands broadcast to every cell at commit
    localparam logic [1:0] UPD_NONE = 2'd0;
    localparam logic [1:0] UPD_INC  = 2'd1;
    localparam logic [1:0] UPD_INS  = 2'd2;
    localparam logic [1:0] UPD_CLR  = 2'd3;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic [1:0]           op;
        logic [IDX_MAX_W-1:0] idx;
    } t_upd;

    // Control flags that travel with the scan along the chain
    typedef struct packed {
        logic stb;
        logic found;
        logic vic_vld;
        logic free_vld;
    } t_scan;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_BITS'(1);
    endfunction

endpackage

// ===== design/mfec_if.sv =====
// ----------------------------------------------------------------------------
// mfec_if
// Request and response channels of the most-frequent-evict store.
// ----------------------------------------------------------------------------
interface mfec_req_if #(parameter int KEY_BITS = 20);
    logic                valid;
    logic                ready;
    logic                func;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface mfec_rsp_if #(parameter int KEY_BITS = 20);
    logic                valid;
    logic                ready;
    logic                hit;
    logic                evicted;
    logic [KEY_BITS-1:0] evicted_key;
    logic [31:0]         evict_total;

    modport source (output valid, output hit, output evicted, output evicted_key,
                    output evict_total, input ready);
    modport sink   (input valid, input hit, input evicted, input evicted_key,
                    input evict_total, output ready);
endinterface

// ===== design/mfec_cell.sv =====
// ----------------------------------------------------------------------------
// mfec_cell
// One store slot plus one stage of the match / victim / free-slot scan.
// ----------------------------------------------------------------------------
module mfec_cell import mfec_pkg::*; #(
    parameter int KEY_BITS = 20,
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4,
    parameter int OCC_W    = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KEY_BITS-1:0] i_key,
    input  t_upd                i_upd,
    input  logic [CNT_BITS-1:0] i_stamp,
    input  t_scan               i_flags,
    input  logic [IDX_W-1:0]    i_found_idx,
    input  logic [IDX_W-1:0]    i_vic_idx,
    input  logic [CNT_BITS-1:0] i_vic_cnt,
    input  logic [CNT_BITS-1:0] i_vic_stamp,
    input  logic [KEY_BITS-1:0] i_vic_key,
    input  logic [IDX_W-1:0]    i_free_idx,
    input  logic [OCC_W-1:0]    i_occ,
    output t_scan               o_flags,
    output logic [IDX_W-1:0]    o_found_idx,
    output logic [IDX_W-1:0]    o_vic_idx,
    output logic [CNT_BITS-1:0] o_vic_cnt,
    output logic [CNT_BITS-1:0] o_vic_stamp,
    output logic [KEY_BITS-1:0] o_vic_key,
    output logic [IDX_W-1:0]    o_free_idx,
    output logic [OCC_W-1:0]    o_occ
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] r_stamp;

    t_scan               r_flags;
    logic [IDX_W-1:0]    r_found_idx;
    logic [IDX_W-1:0]    r_vic_idx;
    logic [CNT_BITS-1:0] r_vic_cnt;
    logic [CNT_BITS-1:0] r_vic_stamp;
    logic [KEY_BITS-1:0] r_vic_key;
    logic [IDX_W-1:0]    r_free_idx;
    logic [OCC_W-1:0]    r_occ;

    logic w_sel;
    logic w_match;
    logic w_take;
    logic w_free;

    always_comb begin
        w_sel   = (i_upd.idx == IDX_MAX_W'(CELL_IDX));
        w_match = r_valid && !i_flags.found && (r_key == i_key);
        // higher count wins, earlier stamp breaks a tie, lower slot keeps an exact tie
        w_take  = r_valid && (!i_flags.vic_vld || (r_cnt > i_vic_cnt) ||
                  ((r_cnt == i_vic_cnt) && (r_stamp < i_vic_stamp)));
        w_free  = !r_valid && !i_flags.free_vld;
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd.op == UPD_CLR) begin
            r_valid <= 1'b0;
        end else if (i_upd.op == UPD_INS && w_sel) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_upd.op == UPD_INS) begin
            r_key   <= i_key;
            r_cnt   <= CNT_BITS'(1);
            r_stamp <= i_stamp;
        end else if (w_sel && i_upd.op == UPD_INC) begin
            r_cnt   <= sat_inc(r_cnt);
        end
    end

    // scan stage: advance the strobe every cycle, hold the data between scans
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags.stb <= i_flags.stb;
            if (i_flags.stb) begin
                r_flags.found    <= i_flags.found | w_match;
                r_flags.vic_vld  <= i_flags.vic_vld | w_take;
                r_flags.free_vld <= i_flags.free_vld | w_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flags.stb) begin
            r_found_idx <= w_match ? IDX_W'(CELL_IDX) : i_found_idx;
            r_free_idx  <= w_free ? IDX_W'(CELL_IDX) : i_free_idx;
            r_occ       <= i_occ + OCC_W'(r_valid);
            if (w_take) begin
                r_vic_idx   <= IDX_W'(CELL_IDX);
                r_vic_cnt   <= r_cnt;
                r_vic_stamp <= r_stamp;
                r_vic_key   <= r_key;
            end else begin
                r_vic_idx   <= i_vic_idx;
                r_vic_cnt   <= i_vic_cnt;
                r_vic_stamp <= i_vic_stamp;
                r_vic_key   <= i_vic_key;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_found_idx = r_found_idx;
    assign o_vic_idx   = r_vic_idx;
    assign o_vic_cnt   = r_vic_cnt;
    assign o_vic_stamp = r_vic_stamp;
    assign o_vic_key   = r_vic_key;
    assign o_free_idx  = r_free_idx;
    assign o_occ       = r_occ;

endmodule

// ===== design/most_frequent_evict_cache_policy.sv =====
// An access launches a scan strobe that walks the cell chain one slot per cycle;
// a clear skips the scan. One request is in flight at a time, so a new request
// is taken only after the previous response has been committed; a stalled
// response holds off that commit. Synchronous active-low reset empties every slot,
// zeroes sequence time and eviction total and sets capacity to 16.
// ----------------------------------------------------------------------------
// most_frequent_evict_cache_policy
// Fully associative key store with most-frequently-used replacement.
// ----------------------------------------------------------------------------
module most_frequent_evict_cache_policy import mfec_pkg::*; #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_wdata,
    mfec_req_if.sink            i_req,
    mfec_rsp_if.source          o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CAP_BITS-1:0] r_cap;
    logic                r_func;
    logic [KEY_BITS-1:0] r_key;
    logic                r_launch;
    logic [CNT_BITS-1:0] r_seq, n_seq;
    logic [CNT_BITS-1:0] r_total, n_total;

    logic                r_out_valid;
    logic                r_hit, n_hit;
    logic                r_evicted, n_evicted;
    logic [KEY_BITS-1:0] r_ev_key, n_ev_key;

    t_scan               w_flags     [0:ENTRIES];
    logic [IDX_W-1:0]    w_found_idx [0:ENTRIES];
    logic [IDX_W-1:0]    w_vic_idx   [0:ENTRIES];
    logic [CNT_BITS-1:0] w_vic_cnt   [0:ENTRIES];
    logic [CNT_BITS-1:0] w_vic_stamp [0:ENTRIES];
    logic [KEY_BITS-1:0] w_vic_key   [0:ENTRIES];
    logic [IDX_W-1:0]    w_free_idx  [0:ENTRIES];
    logic [OCC_W-1:0]    w_occ       [0:ENTRIES];

    t_upd                w_upd;
    logic                w_accept;
    logic                w_commit;
    logic                w_full;
    logic [31:0]         w_eff_cap;
    t_scan               w_last;

    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign w_last = w_flags[ENTRIES];

    // chain head
    assign w_flags[0]     = '{stb: r_launch, found: 1'b0, vic_vld: 1'b0, free_vld: 1'b0};
    assign w_found_idx[0] = '0;
    assign w_vic_idx[0]   = '0;
    assign w_vic_cnt[0]   = '0;
    assign w_vic_stamp[0] = '0;
    assign w_vic_key[0]   = '0;
    assign w_free_idx[0]  = '0;
    assign w_occ[0]       = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mfec_cell #(
            .KEY_BITS (KEY_BITS),
            .CELL_IDX (g),
            .IDX_W    (IDX_W),
            .OCC_W    (OCC_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_upd       (w_upd),
            .i_stamp     (n_seq),
            .i_flags     (w_flags[g]),
            .i_found_idx (w_found_idx[g]),
            .i_vic_idx   (w_vic_idx[g]),
            .i_vic_cnt   (w_vic_cnt[g]),
            .i_vic_stamp (w_vic_stamp[g]),
            .i_vic_key   (w_vic_key[g]),
            .i_free_idx  (w_free_idx[g]),
            .i_occ       (w_occ[g]),
            .o_flags     (w_flags[g+1]),
            .o_found_idx (w_found_idx[g+1]),
            .o_vic_idx   (w_vic_idx[g+1]),
            .o_vic_cnt   (w_vic_cnt[g+1]),
            .o_vic_stamp (w_vic_stamp[g+1]),
            .o_vic_key   (w_vic_key[g+1]),
            .o_free_idx  (w_free_idx[g+1]),
            .o_occ       (w_occ[g+1])
        );
    end

    // capacity 0 acts as 1, anything above the slot count as the slot count
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = 32'd1;
        end else if (32'(r_cap) > 32'(ENTRIES)) begin
            w_eff_cap = 32'(ENTRIES);
        end else begin
            w_eff_cap = 32'(r_cap);
        end
        w_full = (32'(w_occ[ENTRIES]) >= w_eff_cap) && w_last.vic_vld;
    end

    always_comb begin
        n_state   = r_state;
        n_seq     = r_seq;
        n_total   = r_total;
        n_hit     = 1'b0;
        n_evicted = 1'b0;
        n_ev_key  = '0;
        w_upd     = '{op: UPD_NONE, idx: '0};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.func == FUNC_CLEAR) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last.stb) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (r_func == FUNC_CLEAR) begin
                    n_seq   = '0;
                    n_total = '0;
                    if (w_commit) begin
                        w_upd = '{op: UPD_CLR, idx: '0};
                    end
                end else begin
                    n_seq = sat_inc(r_seq);
                    if (w_last.found) begin
                        n_hit = 1'b1;
                        if (w_commit) begin
                            w_upd = '{op: UPD_INC, idx: IDX_MAX_W'(w_found_idx[ENTRIES])};
                        end
                    end else if (w_full) begin
                        n_evicted = 1'b1;
                        n_ev_key  = w_vic_key[ENTRIES];
                        n_total   = sat_inc(r_total);
                        if (w_commit) begin
                            w_upd = '{op: UPD_INS, idx: IDX_MAX_W'(w_vic_idx[ENTRIES])};
                        end
                    end else if (w_last.free_vld && w_commit) begin
                        w_upd = '{op: UPD_INS, idx: IDX_MAX_W'(w_free_idx[ENTRIES])};
                    end
                end
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_launch    <= 1'b0;
            r_seq       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept && (i_req.func == FUNC_ACCESS);
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_commit) begin
                r_seq       <= n_seq;
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_req.func;
            r_key  <= i_req.key;
        end
        if (w_commit) begin
            r_hit     <= n_hit;
            r_evicted <= n_evicted;
            r_ev_key  <= n_ev_key;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_hit;
    assign o_rsp.evicted     = r_evicted;
    assign o_rsp.evicted_key = r_ev_key;
    assign o_rsp.evict_total = r_total;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request taken while idle state held");

    a_scan_end_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.stb |-> (r_state == S_SCAN))
        else $error("scan strobe left chain outside scan state");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_rsp.hit) |-> (!o_rsp.evicted && (o_rsp.evicted_key == '0)))
        else $error("hit response carries an eviction");

    a_insert_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_func == FUNC_ACCESS) && !w_last.found && !w_full)
        |-> w_last.free_vld)
        else $error("miss below capacity found no free slot");
`endif

endmodule
